@@ rtl/core/rfit_pkg.sv @@
// shared constants for the row find-or-insert table
// no dependencies; compiled before all other files
package rfit_pkg;

    localparam int ELEM_W       = 32;
    localparam int IDX_W        = 8;
    localparam int CFG_W        = 5;
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 16;
    localparam int Q_DEPTH      = 2;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(16);

endpackage

@@ rtl/core/rfit_ifs.sv @@
// valid/ready channel interfaces for element beats and result beats
// depends on rfit_pkg
interface rfit_elem_if;
    import rfit_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);
endinterface

interface rfit_res_if;
    import rfit_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;
    logic             was_new;
    logic             table_full;

    modport source (output valid, output row_index, output was_new, output table_full,
                    input ready);
    modport sink (input valid, input row_index, input was_new, input table_full,
                  output ready);
endinterface

@@ rtl/core/rfit_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module rfit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rfit_front.sv @@
// front end: width register, element gathering and a short queue of complete rows
// depends on rfit_pkg and rfit_ifs
module rfit_front #(
    parameter int MAX_COLS = rfit_pkg::DEF_MAX_COLS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [rfit_pkg::CFG_W-1:0]               cfg_wr_data,
    rfit_elem_if.sink                                element,
    output logic [$clog2(MAX_COLS+1)-1:0]            width_act,
    output logic                                     row_avail,
    input  logic                                     row_pop,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_col,
    output logic [rfit_pkg::ELEM_W-1:0]              rd_word
);
    import rfit_pkg::*;

    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    logic [CFG_W-1:0]  row_width_reg;
    logic [CNW-1:0]    col_reg, col_next;
    logic [QPW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]    q_cnt_reg, q_cnt_next;
    logic [ELEM_W-1:0] q_mem [Q_DEPTH][MAX_COLS];
    logic              accept;
    logic              push;
    logic              last_col;

    // clamp the programmed width into 1..MAX_COLS
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            width_act = CNW'(1);
        end
        else if (32'(row_width_reg) > 32'(MAX_COLS))
        begin
            width_act = CNW'(MAX_COLS);
        end
        else
        begin
            width_act = CNW'(row_width_reg);
        end
    end

    assign element.ready = (q_cnt_reg != QCW'(Q_DEPTH));
    assign accept        = element.valid && element.ready;
    assign last_col      = ((col_reg + CNW'(1)) == width_act);
    assign push          = accept && last_col;
    assign row_avail     = (q_cnt_reg != '0);
    assign rd_word       = q_mem[rd_ptr_reg][rd_col];

    always_comb
    begin
        col_next    = col_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (accept)
        begin
            col_next = last_col ? '0 : (col_reg + CNW'(1));
        end
        if (cfg_wr_en)
        begin
            col_next = '0;
        end
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPW'(1);
        end
        if (row_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPW'(1);
        end
        q_cnt_next = q_cnt_reg + QCW'(push) - QCW'(row_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            col_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            q_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                row_width_reg <= cfg_wr_data;
            end
            col_reg    <= col_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // row payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg][col_reg[CIW-1:0]] <= element.element_value;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_cnt_reg != QCW'(Q_DEPTH)))
        else $error("row pushed into full queue");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (col_reg < width_act))
        else $error("column position beyond row width");

    a_cfg_restarts_row: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (col_reg == '0))
        else $error("width write did not restart the row");
`endif

endmodule

@@ rtl/core/rfit_back.sv @@
// back end: sequential search of stored rows, append on miss, result register
// depends on rfit_pkg and rfit_ifs; drives the row store ram ports
module rfit_back #(
    parameter int MAX_ROWS = rfit_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rfit_pkg::DEF_MAX_COLS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [$clog2(MAX_COLS+1)-1:0]              width_act,
    input  logic                                       row_avail,
    output logic                                       row_pop,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_col,
    input  logic [rfit_pkg::ELEM_W-1:0]                rd_word,
    output logic                                       ram_we,
    output logic                                       ram_re,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       ram_addr,
    output logic [rfit_pkg::ELEM_W-1:0]                ram_wdata,
    input  logic [rfit_pkg::ELEM_W-1:0]                ram_rdata,
    rfit_res_if.source                                 result
);
    import rfit_pkg::*;

    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CTW = $clog2(MAX_ROWS + 1);
    localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_CMP    = 5'b00100,
        S_WRITE  = 5'b01000,
        S_RESULT = 5'b10000
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [RW-1:0]    r_reg, r_next;
    logic [CNW-1:0]   c_reg, c_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [CTW-1:0]   count_reg, count_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_new_reg, res_new_next;
    logic             res_full_reg, res_full_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_new_reg;
    logic             out_full_reg;
    logic             out_load;
    logic             col_last;
    logic             is_full;
    logic [IDX_W+RW-1:0] r_ext;
    logic [IDX_W+RW-1:0] cnt_ext;

    assign col_last  = ((c_reg + CNW'(1)) == width_act);
    assign is_full   = (32'(count_reg) >= 32'(MAX_ROWS));
    assign r_ext     = {IDX_W'(0), r_reg};
    assign cnt_ext   = {IDX_W'(0), count_reg[RW-1:0]};
    assign rd_col    = c_reg[CIW-1:0];
    assign ram_addr  = base_reg + AW'(c_reg);
    assign ram_wdata = rd_word;
    assign ram_re    = (state_reg == S_READ);
    assign ram_we    = (state_reg == S_WRITE);
    assign out_load  = (state_reg == S_RESULT) && (!out_valid_reg || result.ready);
    assign row_pop   = out_load;

    always_comb
    begin
        state_next    = state_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        base_next     = base_reg;
        count_next    = count_reg;
        res_idx_next  = res_idx_reg;
        res_new_next  = res_new_reg;
        res_full_next = res_full_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                r_next    = '0;
                c_next    = '0;
                base_next = '0;
                if (row_avail)
                begin
                    state_next = (count_reg == '0) ? S_WRITE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (ram_rdata == rd_word && col_last)
                begin
                    res_idx_next  = r_ext[IDX_W-1:0];
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = S_RESULT;
                end
                else if (ram_rdata == rd_word)
                begin
                    c_next     = c_reg + CNW'(1);
                    state_next = S_READ;
                end
                else if ((CTW'(r_reg) + CTW'(1)) == count_reg)
                begin
                    c_next    = '0;
                    base_next = base_reg + AW'(MAX_COLS);
                    if (is_full)
                    begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                        state_next    = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    c_next     = '0;
                    base_next  = base_reg + AW'(MAX_COLS);
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                if (col_last)
                begin
                    res_idx_next  = cnt_ext[IDX_W-1:0];
                    res_new_next  = 1'b1;
                    res_full_next = 1'b0;
                    count_next    = count_reg + CTW'(1);
                    state_next    = S_RESULT;
                end
                else
                begin
                    c_next = c_reg + CNW'(1);
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // search position, pending result and output beat, no reset
    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        c_reg        <= c_next;
        base_reg     <= base_next;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        if (out_load)
        begin
            out_idx_reg  <= res_idx_reg;
            out_new_reg  <= res_new_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.row_index  = out_idx_reg;
    assign result.was_new    = out_new_reg;
    assign result.table_full = out_full_reg;

`ifndef SYNTHESIS
    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(count_reg) < 32'(MAX_ROWS)))
        else $error("row store written while table full");

    a_pop_has_row: assert property (@(posedge clk) disable iff (!rst_n)
        row_pop |-> row_avail)
        else $error("queue popped while empty");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CTW'(1)))
        else $error("row count moved by other than one");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_READ))
        else $error("compare without a preceding ram read");
`endif

endmodule

@@ rtl/core/row_find_or_insert_table.sv @@
// top level of the row find-or-insert table: front end, back end and row store ram
// depends on rfit_pkg, rfit_ifs, rfit_ram, rfit_front and rfit_back
//
// Rows arrive as w element beats (w is the row_width register, clamped to 1..MAX_COLS)
// and each complete row yields exactly one result beat: the index of the first
// stored row that matches, or the index of the newly appended row with was_new
// set, or table_full when no row matches and MAX_ROWS rows are stored. The front
// end accepts one element per cycle while its queue has room and buffers up to two
// complete rows, so it keeps taking beats while the back end searches. The search
// reads the row store through the single ram read port, each word by address then
// compare, moving to the next row at the first mismatching word. An append writes
// w words, one per cycle. The row store needs no clearing after reset: only rows
// below the stored row count are ever read. Write row_width only while no row is
// in flight; a write discards a partly delivered row.
module row_find_or_insert_table #(
    parameter int MAX_ROWS = rfit_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rfit_pkg::DEF_MAX_COLS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rfit_pkg::CFG_W-1:0] cfg_wr_data,
    rfit_elem_if.sink                  element,
    rfit_res_if.source                 result
);
    import rfit_pkg::*;

    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);

    logic [CNW-1:0]    width_act;
    logic              row_avail;
    logic              row_pop;
    logic [CIW-1:0]    rd_col;
    logic [ELEM_W-1:0] rd_word;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [ELEM_W-1:0] ram_wdata;
    logic [ELEM_W-1:0] ram_rdata;

    rfit_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .element     (element),
        .width_act   (width_act),
        .row_avail   (row_avail),
        .row_pop     (row_pop),
        .rd_col      (rd_col),
        .rd_word     (rd_word)
    );

    rfit_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .width_act (width_act),
        .row_avail (row_avail),
        .row_pop   (row_pop),
        .rd_col    (rd_col),
        .rd_word   (rd_word),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

    rfit_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

endmodule
